// ===== design/lpsp_pkg.sv =====
package lpsp_pkg;

    localparam int MAX_PIXELS = 1024;

    localparam int BYTE_W  = 8;
    localparam int LIMIT_W = 11;
    localparam int THR_W   = 4;
    localparam int ESC_W   = 4;
    localparam int IDX_W   = 10;
    localparam int ADDR_W  = 16;
    localparam int KIND_W  = 2;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam int OUT_DW  = 56;

    localparam logic [LIMIT_W-1:0] PIX_CAP       = LIMIT_W'(MAX_PIXELS);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = LIMIT_W'(1024);
    localparam logic [THR_W-1:0]   THR_RESET     = THR_W'(8);
    localparam logic [ESC_W-1:0]   ESC_MAX       = '1;
    localparam logic [ESC_W-1:0]   ESC_FIRST     = ESC_W'(1);

    localparam logic [BYTE_W-1:0]  ESCAPE_BYTE   = 8'hFF;
    localparam logic [BYTE_W-1:0]  CMD_PROGRAM   = 8'h70;

    localparam logic [KIND_W-1:0]  KIND_PIXEL    = 2'd0;
    localparam logic [KIND_W-1:0]  KIND_SHOW     = 2'd1;
    localparam logic [KIND_W-1:0]  KIND_PROGRAM  = 2'd2;

    localparam logic REG_PIXEL_LIMIT      = 1'b0;
    localparam logic REG_ESCAPE_THRESHOLD = 1'b1;

    typedef struct packed {
        logic [LIMIT_W-1:0] pixel_limit;
        logic [THR_W-1:0]   escape_threshold;
    } cfg_t;

    typedef struct packed {
        logic               hit;
        logic [KIND_W-1:0]  event_kind;
        logic [IDX_W-1:0]   pixel_index;
        logic [BYTE_W-1:0]  red;
        logic [BYTE_W-1:0]  green;
        logic [BYTE_W-1:0]  blue;
        logic [ADDR_W-1:0]  device_address;
    } result_t;

endpackage

// ===== design/led_pixel_stream_parser_unit.sv =====
// path: a byte is held in the input register, then its result in the output register
// throughput: one byte per cycle while no output request is held off, set by the single pass from
// input register to result register; a byte waits in the input register while an output request is
// held off, bytes without an event produce no output request
// reset (rst_n, async, active low): data mode, counters and positions cleared,
// pixel_limit 1024, escape_threshold 8, no pending request
module led_pixel_stream_parser_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpsp_pkg::APB_AW-1:0]   paddr,
    input  logic [lpsp_pkg::APB_DW-1:0]   pwdata,
    output logic [lpsp_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lpsp_pkg::BYTE_W-1:0]   s_tdata,   // rx_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pixel_index[9:0], red[17:10], green[25:18], blue[33:26], device_address[49:34], zero
    output logic [lpsp_pkg::OUT_DW-1:0]   m_tdata,
    output logic [lpsp_pkg::KIND_W-1:0]   m_tuser    // event_kind
);

    lpsp_pkg::cfg_t                cfg;
    lpsp_pkg::result_t             res;
    logic                          in_valid_reg, in_valid_next;
    logic [lpsp_pkg::BYTE_W-1:0]   in_byte_reg, in_byte_next;
    logic                          out_free;
    logic                          advance;

    lpsp_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
        end
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
    end

    lpsp_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .res     (res)
    );

    lpsp_out u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && res.hit),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // a byte in the input register is never processed while a result is stuck
    a_no_step_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !advance)
        else $error("byte processed while output request stalled");

    // an event produced by the parser shows up on the master side next cycle
    a_event_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.hit) |=> (m_tvalid && m_tuser == $past(res.event_kind)))
        else $error("parser event lost before output");

    // an empty input register always takes a new byte
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stalled with empty input register");

endmodule

// ===== design/lpsp_regs.sv =====
module lpsp_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpsp_pkg::APB_AW-1:0]   paddr,
    input  logic [lpsp_pkg::APB_DW-1:0]   pwdata,
    output logic [lpsp_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output lpsp_pkg::cfg_t                cfg
);

    logic [lpsp_pkg::LIMIT_W-1:0] limit_reg, limit_next;
    logic [lpsp_pkg::THR_W-1:0]   thr_reg, thr_next;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        limit_next = limit_reg;
        thr_next   = thr_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                lpsp_pkg::REG_PIXEL_LIMIT:
                    limit_next = pwdata[lpsp_pkg::LIMIT_W-1:0];
                lpsp_pkg::REG_ESCAPE_THRESHOLD:
                    thr_next = pwdata[lpsp_pkg::THR_W-1:0];
                default:
                    limit_next = limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= lpsp_pkg::LIMIT_RESET;
            thr_reg   <= lpsp_pkg::THR_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
            thr_reg   <= thr_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            lpsp_pkg::REG_PIXEL_LIMIT:
                prdata = lpsp_pkg::APB_DW'(limit_reg);
            lpsp_pkg::REG_ESCAPE_THRESHOLD:
                prdata = lpsp_pkg::APB_DW'(thr_reg);
            default:
                prdata = '0;
        endcase
    end

    assign cfg.pixel_limit      = limit_reg;
    assign cfg.escape_threshold = thr_reg;

endmodule

// ===== design/lpsp_core.sv =====
module lpsp_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [lpsp_pkg::BYTE_W-1:0]   rx_byte,
    input  lpsp_pkg::cfg_t                cfg,
    output lpsp_pkg::result_t             res
);

    localparam logic [1:0] CPOS_OPCODE  = 2'd0;
    localparam logic [1:0] CPOS_ADDR_HI = 2'd1;
    localparam logic [1:0] CPOS_ADDR_LO = 2'd2;
    localparam logic [1:0] CPOS_BAD     = 2'd3;

    logic                          cmd_reg, cmd_next;
    logic [lpsp_pkg::ESC_W-1:0]    esc_reg, esc_next, esc_inc;
    logic [1:0]                    tri_reg, tri_next;
    logic [1:0]                    cpos_reg, cpos_next;
    logic [lpsp_pkg::LIMIT_W-1:0]  np_reg, np_next, eff_limit;
    logic [lpsp_pkg::BYTE_W-1:0]   held0_reg, held0_next;
    logic [lpsp_pkg::BYTE_W-1:0]   held1_reg, held1_next;
    logic [lpsp_pkg::BYTE_W-1:0]   addr_hi_reg, addr_hi_next;
    logic                          is_esc;

    assign is_esc    = (rx_byte == lpsp_pkg::ESCAPE_BYTE);
    assign eff_limit = (cfg.pixel_limit > lpsp_pkg::PIX_CAP) ? lpsp_pkg::PIX_CAP
                                                             : cfg.pixel_limit;
    assign esc_inc   = (esc_reg < lpsp_pkg::ESC_MAX) ? esc_reg + 1'b1 : esc_reg;

    always_comb
    begin
        cmd_next     = cmd_reg;
        esc_next     = esc_reg;
        tri_next     = tri_reg;
        cpos_next    = cpos_reg;
        np_next      = np_reg;
        held0_next   = held0_reg;
        held1_next   = held1_reg;
        addr_hi_next = addr_hi_reg;
        res          = '0;

        if (step)
        begin
            if (cmd_reg)
            begin
                if (!is_esc)
                begin
                    unique case (cpos_reg)
                        CPOS_OPCODE:
                        begin
                            if (rx_byte == lpsp_pkg::CMD_PROGRAM)
                                cpos_next = CPOS_ADDR_HI;
                            else
                            begin
                                cmd_next  = 1'b0;
                                tri_next  = '0;
                                np_next   = '0;
                                esc_next  = '0;
                                cpos_next = CPOS_OPCODE;
                            end
                        end
                        CPOS_ADDR_HI:
                        begin
                            addr_hi_next = rx_byte;
                            cpos_next    = CPOS_ADDR_LO;
                        end
                        CPOS_ADDR_LO, CPOS_BAD:
                        begin
                            cmd_next  = 1'b0;
                            tri_next  = '0;
                            np_next   = '0;
                            esc_next  = '0;
                            cpos_next = CPOS_OPCODE;
                            if (cpos_reg == CPOS_ADDR_LO)
                            begin
                                res.hit            = 1'b1;
                                res.event_kind     = lpsp_pkg::KIND_PROGRAM;
                                res.device_address = {addr_hi_reg, rx_byte};
                            end
                        end
                        default:
                            cpos_next = CPOS_OPCODE;
                    endcase
                end
            end
            else if (!is_esc)
            begin
                esc_next = '0;
                if (tri_reg < 2'd2)
                begin
                    if (tri_reg[0])
                        held1_next = rx_byte;
                    else
                        held0_next = rx_byte;
                    tri_next = tri_reg + 2'd1;
                end
                else
                begin
                    tri_next = '0;
                    if (np_reg < eff_limit)
                    begin
                        res.hit         = 1'b1;
                        res.event_kind  = lpsp_pkg::KIND_PIXEL;
                        res.pixel_index = np_reg[lpsp_pkg::IDX_W-1:0];
                        res.red         = held0_reg;
                        res.green       = held1_reg;
                        res.blue        = rx_byte;
                        np_next         = np_reg + 1'b1;
                    end
                end
            end
            else
            begin
                tri_next = '0;
                np_next  = '0;
                esc_next = esc_inc;
                if (esc_inc > cfg.escape_threshold)
                begin
                    cmd_next  = 1'b1;
                    cpos_next = CPOS_OPCODE;
                end
                if (esc_inc == lpsp_pkg::ESC_FIRST)
                begin
                    res.hit        = 1'b1;
                    res.event_kind = lpsp_pkg::KIND_SHOW;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg  <= 1'b0;
            esc_reg  <= '0;
            tri_reg  <= '0;
            cpos_reg <= CPOS_OPCODE;
            np_reg   <= '0;
        end
        else
        begin
            cmd_reg  <= cmd_next;
            esc_reg  <= esc_next;
            tri_reg  <= tri_next;
            cpos_reg <= cpos_next;
            np_reg   <= np_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held0_reg   <= held0_next;
        held1_reg   <= held1_next;
        addr_hi_reg <= addr_hi_next;
    end

endmodule

// ===== design/lpsp_out.sv =====
module lpsp_out
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  lpsp_pkg::result_t             res,
    output logic                          free,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lpsp_pkg::OUT_DW-1:0]   m_tdata,
    output logic [lpsp_pkg::KIND_W-1:0]   m_tuser
);

    logic                          valid_reg, valid_next;
    logic [lpsp_pkg::OUT_DW-1:0]   data_reg, data_next;
    logic [lpsp_pkg::KIND_W-1:0]   kind_reg, kind_next;

    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        kind_next  = kind_reg;
        if (load)
        begin
            valid_next = 1'b1;
            kind_next  = res.event_kind;
            data_next  = lpsp_pkg::OUT_DW'({res.device_address, res.blue, res.green,
                                             res.red, res.pixel_index});
        end
        else if (m_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        kind_reg <= kind_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;

endmodule

// ===== tb/tb_led_pixel_stream_parser_unit.sv =====
module tb_led_pixel_stream_parser_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned DRAIN_CYCLES   = 4;
    localparam int unsigned TAIL_CYCLES    = 8;
    localparam int unsigned PHASE_BYTES    = 132;
    localparam int unsigned NUM_PHASES     = 10;

    localparam logic [lpsp_pkg::APB_AW-1:0] ADDR_LIMIT     =
        {lpsp_pkg::REG_PIXEL_LIMIT, 2'b00};
    localparam logic [lpsp_pkg::APB_AW-1:0] ADDR_THRESHOLD =
        {lpsp_pkg::REG_ESCAPE_THRESHOLD, 2'b00};

    typedef struct packed {
        logic [lpsp_pkg::KIND_W-1:0] event_kind;
        logic [lpsp_pkg::IDX_W-1:0]  pixel_index;
        logic [lpsp_pkg::BYTE_W-1:0] red;
        logic [lpsp_pkg::BYTE_W-1:0] green;
        logic [lpsp_pkg::BYTE_W-1:0] blue;
        logic [lpsp_pkg::ADDR_W-1:0] device_address;
    } led_event_t;

    typedef enum logic [1:0] {ROW_BYTE, ROW_LIMIT, ROW_THRESHOLD} row_op_e;

    typedef struct packed {
        row_op_e    op;
        logic [15:0] value;
        logic        fixed;
        led_event_t  ev;
    } stim_row_t;

    localparam led_event_t NO_EVENT   = '0;
    localparam led_event_t SHOW_EVENT = {lpsp_pkg::KIND_SHOW, 50'd0};

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [lpsp_pkg::APB_AW-1:0]     paddr;
    logic [lpsp_pkg::APB_DW-1:0]     pwdata;
    logic [lpsp_pkg::APB_DW-1:0]     prdata;
    logic                            pready;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [lpsp_pkg::BYTE_W-1:0]     s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [lpsp_pkg::OUT_DW-1:0]     m_tdata;
    logic [lpsp_pkg::KIND_W-1:0]     m_tuser;

    // parser shadow state
    logic                            cmd_active;
    logic [lpsp_pkg::ESC_W-1:0]      esc_run;
    logic [1:0]                      rgb_pos;
    logic [lpsp_pkg::BYTE_W-1:0]     rgb_hold [2];
    logic [lpsp_pkg::LIMIT_W-1:0]    pix_next;
    logic [1:0]                      cmd_pos;
    logic [lpsp_pkg::BYTE_W-1:0]     addr_hi;
    logic [lpsp_pkg::LIMIT_W-1:0]    cur_limit;
    logic [lpsp_pkg::THR_W-1:0]      cur_thr;

    led_event_t          led_events_due[$];
    stim_row_t           dir_rows[$];
    int unsigned         mismatch_count;
    int unsigned         sent_bytes;
    int unsigned         idle_cycles;
    bit                  src_calm;
    bit                  hold_request;

    led_pixel_stream_parser_unit i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic void clear_parser();
        cmd_active = 1'b0;
        rgb_pos    = '0;
        pix_next   = '0;
        esc_run    = '0;
        cmd_pos    = '0;
    endfunction

    function automatic bit parse_byte(input logic [lpsp_pkg::BYTE_W-1:0] c,
                                      output led_event_t ev);
        logic [lpsp_pkg::LIMIT_W-1:0] cap;
        ev = NO_EVENT;
        if (cmd_active)
        begin
            if (c == lpsp_pkg::ESCAPE_BYTE)
                return 1'b0;
            case (cmd_pos)
                2'd0:
                begin
                    if (c == lpsp_pkg::CMD_PROGRAM)
                        cmd_pos = 2'd1;
                    else
                        clear_parser();
                    return 1'b0;
                end
                2'd1:
                begin
                    addr_hi = c;
                    cmd_pos = 2'd2;
                    return 1'b0;
                end
                2'd2:
                begin
                    clear_parser();
                    ev.event_kind     = lpsp_pkg::KIND_PROGRAM;
                    ev.device_address = {addr_hi, c};
                    return 1'b1;
                end
                default:
                begin
                    clear_parser();
                    return 1'b0;
                end
            endcase
        end
        if (c != lpsp_pkg::ESCAPE_BYTE)
        begin
            esc_run = '0;
            if (rgb_pos < 2'd2)
            begin
                rgb_hold[rgb_pos[0]] = c;
                rgb_pos++;
                return 1'b0;
            end
            rgb_pos = '0;
            cap = (cur_limit > lpsp_pkg::PIX_CAP) ? lpsp_pkg::PIX_CAP : cur_limit;
            if (pix_next < cap)
            begin
                ev.event_kind  = lpsp_pkg::KIND_PIXEL;
                ev.pixel_index = pix_next[lpsp_pkg::IDX_W-1:0];
                ev.red         = rgb_hold[0];
                ev.green       = rgb_hold[1];
                ev.blue        = c;
                pix_next++;
                return 1'b1;
            end
            return 1'b0;
        end
        rgb_pos  = '0;
        pix_next = '0;
        if (esc_run != lpsp_pkg::ESC_MAX)
            esc_run++;
        if (esc_run > cur_thr)
        begin
            cmd_active = 1'b1;
            cmd_pos    = '0;
        end
        if (esc_run == lpsp_pkg::ESC_FIRST)
        begin
            ev.event_kind = lpsp_pkg::KIND_SHOW;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int unsigned idle_len(input bit calm);
        int unsigned r;
        r = $urandom_range(99);
        if (calm || r < 55)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s: expected %h, got %h", what, want, got);
    endtask

    task automatic send_byte(input logic [lpsp_pkg::BYTE_W-1:0] b, input bit fixed,
                             input led_event_t fixed_ev);
        led_event_t  ev;
        bit          hit;
        int unsigned gap;
        if (sent_bytes % 64 == 0)
            src_calm = ($urandom_range(3) == 0);
        gap = idle_len(src_calm);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        hit = parse_byte(b, ev);
        if (fixed)
            led_events_due.push_back(fixed_ev);
        else if (hit)
            led_events_due.push_back(ev);
        sent_bytes++;
    endtask

    task automatic send_escapes(input int unsigned n);
        repeat (n) send_byte(lpsp_pkg::ESCAPE_BYTE, 1'b0, NO_EVENT);
    endtask

    task automatic send_color();
        send_byte(lpsp_pkg::BYTE_W'($urandom_range(254)), 1'b0, NO_EVENT);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (led_events_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_cycle(input logic wr, input logic [lpsp_pkg::APB_AW-1:0] addr,
                             input logic [lpsp_pkg::APB_DW-1:0] wdata,
                             output logic [lpsp_pkg::APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
    endtask

    task automatic write_reg(input logic [lpsp_pkg::APB_AW-1:0] addr,
                             input logic [lpsp_pkg::APB_DW-1:0] data);
        logic [lpsp_pkg::APB_DW-1:0] readback;
        logic [lpsp_pkg::APB_DW-1:0] held;
        drain();
        apb_cycle(1'b1, addr, data, readback);
        if (addr == ADDR_LIMIT)
        begin
            cur_limit = data[lpsp_pkg::LIMIT_W-1:0];
            held      = lpsp_pkg::APB_DW'(cur_limit);
        end
        else
        begin
            cur_thr = data[lpsp_pkg::THR_W-1:0];
            held    = lpsp_pkg::APB_DW'(cur_thr);
        end
        apb_cycle(1'b0, addr, '0, readback);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== held)
            report_mismatch("register readback", held, readback);
    endtask

    task automatic add_row(input row_op_e op, input logic [15:0] value, input bit fixed,
                           input led_event_t ev);
        dir_rows.push_back({op, value, fixed, ev});
    endtask

    task automatic send_random_sequence();
        int unsigned                 pick;
        int unsigned                 n;
        int unsigned                 run;
        logic [lpsp_pkg::BYTE_W-1:0] c;
        pick = $urandom_range(99);
        if (cur_thr == lpsp_pkg::ESC_MAX)
            run = $urandom_range(15, 20);
        else
            run = int'(cur_thr) + 1 + ($urandom_range(3) == 0);
        if (pick < 45)
        begin
            // frame of triples, sometimes past a small limit, maybe a partial triple
            send_escapes(1 + ($urandom_range(7) == 0));
            n = ($urandom_range(9) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 8);
            repeat (3 * n + $urandom_range(2)) send_color();
        end
        else if (pick < 65)
        begin
            send_escapes(run);
            send_byte(lpsp_pkg::CMD_PROGRAM, 1'b0, NO_EVENT);
            if ($urandom_range(4) == 0)
                send_escapes(1);
            send_color();
            if ($urandom_range(4) == 0)
                send_escapes(1);
            send_color();
        end
        else if (pick < 75)
        begin
            // unknown command
            send_escapes(run);
            do c = lpsp_pkg::BYTE_W'($urandom_range(254));
            while (c == lpsp_pkg::CMD_PROGRAM);
            send_byte(c, 1'b0, NO_EVENT);
        end
        else if (pick < 85)
        begin
            // escape run too short for command mode
            send_escapes($urandom_range(cur_thr));
            send_byte(lpsp_pkg::CMD_PROGRAM, 1'b0, NO_EVENT);
            repeat ($urandom_range(1, 4)) send_color();
        end
        else
        begin
            repeat ($urandom_range(1, 12))
            begin
                c = ($urandom_range(7) == 0) ? lpsp_pkg::ESCAPE_BYTE
                                             : lpsp_pkg::BYTE_W'($urandom_range(255));
                send_byte(c, 1'b0, NO_EVENT);
            end
        end
    endtask

    // result side
    always @(posedge clk)
    begin : result_check
        led_event_t want;
        led_event_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.event_kind     = m_tuser;
            got.pixel_index    = m_tdata[9:0];
            got.red            = m_tdata[17:10];
            got.green          = m_tdata[25:18];
            got.blue           = m_tdata[33:26];
            got.device_address = m_tdata[49:34];
            if (led_events_due.size() == 0)
            begin
                report_mismatch("event with nothing pending, kind", '0, 32'(got.event_kind));
            end
            else
            begin
                want = led_events_due.pop_front();
                if (want.event_kind !== got.event_kind)
                    report_mismatch("event_kind", 32'(want.event_kind), 32'(got.event_kind));
                if (want.pixel_index !== got.pixel_index)
                    report_mismatch("pixel_index", 32'(want.pixel_index), 32'(got.pixel_index));
                if (want.red !== got.red)
                    report_mismatch("red", 32'(want.red), 32'(got.red));
                if (want.green !== got.green)
                    report_mismatch("green", 32'(want.green), 32'(got.green));
                if (want.blue !== got.blue)
                    report_mismatch("blue", 32'(want.blue), 32'(got.blue));
                if (want.device_address !== got.device_address)
                    report_mismatch("device_address", 32'(want.device_address),
                                    32'(got.device_address));
            end
        end
    end

    // receiver readiness, with one long hold-off on request
    initial
    begin : sink
        int unsigned gap;
        int unsigned cycles;
        bit          calm;
        m_tready <= 1'b0;
        calm   = 1'b0;
        cycles = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles % 128 == 0)
                calm = ($urandom_range(3) == 0);
            gap = idle_len(calm);
            if (hold_request)
            begin
                hold_request = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [lpsp_pkg::APB_DW-1:0]  readback;
        logic [lpsp_pkg::LIMIT_W-1:0] limits [NUM_PHASES];
        logic [lpsp_pkg::THR_W-1:0]   thresholds [NUM_PHASES];
        stim_row_t                    row;
        int unsigned                  phase_start;

        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        mismatch_count = 0;
        sent_bytes     = 0;
        idle_cycles    = 0;
        src_calm       = 1'b0;
        hold_request   = 1'b0;
        cur_limit      = 11'd1024;
        cur_thr        = 4'd8;
        rgb_hold[0]    = '0;
        rgb_hold[1]    = '0;
        addr_hi        = '0;
        clear_parser();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // registers after reset
        apb_cycle(1'b0, ADDR_LIMIT, '0, readback);
        if (readback !== 32'd1024)
            report_mismatch("pixel_limit after reset", 32'd1024, readback);
        apb_cycle(1'b0, ADDR_THRESHOLD, '0, readback);
        if (readback !== 32'd8)
            report_mismatch("escape_threshold after reset", 32'd8, readback);
        psel    <= 1'b0;
        penable <= 1'b0;

        // directed part
        add_row(ROW_BYTE, 16'h00FF, 1'b1, SHOW_EVENT);
        add_row(ROW_BYTE, 16'h0000, 1'b0, NO_EVENT);
        add_row(ROW_BYTE, 16'h0080, 1'b0, NO_EVENT);
        add_row(ROW_BYTE, 16'h00FE, 1'b1,
                {lpsp_pkg::KIND_PIXEL, 10'd0, 8'h00, 8'h80, 8'hFE, 16'd0});
        add_row(ROW_BYTE, 16'h007F, 1'b0, NO_EVENT);
        add_row(ROW_BYTE, 16'h0001, 1'b0, NO_EVENT);
        add_row(ROW_BYTE, 16'h0070, 1'b0, NO_EVENT);
        // threshold zero: first escape shows and enters command mode
        add_row(ROW_THRESHOLD, 16'd0, 1'b0, NO_EVENT);
        add_row(ROW_BYTE, 16'h00FF, 1'b1, SHOW_EVENT);
        add_row(ROW_BYTE, 16'h00FF, 1'b0, NO_EVENT);
        add_row(ROW_BYTE, 16'h0070, 1'b0, NO_EVENT);
        add_row(ROW_BYTE, 16'h0000, 1'b0, NO_EVENT);
        add_row(ROW_BYTE, 16'h0000, 1'b1,
                {lpsp_pkg::KIND_PROGRAM, 10'd0, 24'd0, 16'h0000});
        add_row(ROW_BYTE, 16'h00FF, 1'b1, SHOW_EVENT);
        add_row(ROW_BYTE, 16'h0070, 1'b0, NO_EVENT);
        add_row(ROW_BYTE, 16'h00FE, 1'b0, NO_EVENT);
        add_row(ROW_BYTE, 16'h00FF, 1'b0, NO_EVENT);
        add_row(ROW_BYTE, 16'h0001, 1'b1,
                {lpsp_pkg::KIND_PROGRAM, 10'd0, 24'd0, 16'hFE01});
        // unknown command resets silently
        add_row(ROW_BYTE, 16'h00FF, 1'b1, SHOW_EVENT);
        add_row(ROW_BYTE, 16'h0041, 1'b0, NO_EVENT);
        // limit of one pixel, so the second triple gives no event; escape threshold at its maximum
        add_row(ROW_LIMIT, 16'd1, 1'b0, NO_EVENT);
        add_row(ROW_THRESHOLD, 16'd15, 1'b0, NO_EVENT);
        add_row(ROW_BYTE, 16'h0010, 1'b0, NO_EVENT);
        add_row(ROW_BYTE, 16'h0020, 1'b0, NO_EVENT);
        add_row(ROW_BYTE, 16'h0030, 1'b0, NO_EVENT);
        add_row(ROW_BYTE, 16'h0040, 1'b0, NO_EVENT);
        add_row(ROW_BYTE, 16'h0050, 1'b0, NO_EVENT);
        add_row(ROW_BYTE, 16'h0060, 1'b0, NO_EVENT);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            case (row.op)
                ROW_LIMIT:     write_reg(ADDR_LIMIT, lpsp_pkg::APB_DW'(row.value));
                ROW_THRESHOLD: write_reg(ADDR_THRESHOLD, lpsp_pkg::APB_DW'(row.value));
                default:       send_byte(row.value[lpsp_pkg::BYTE_W-1:0], row.fixed, row.ev);
            endcase
        end

        // random part, one register setting per phase
        limits     = '{11'd1024, 11'd0, 11'd2047, 11'd1, 11'd5, 11'd1023, 11'd2,
                       lpsp_pkg::LIMIT_W'($urandom_range(2047)), 11'd3,
                       lpsp_pkg::LIMIT_W'($urandom_range(2047))};
        thresholds = '{4'd8, 4'd0, 4'd14, 4'd15, 4'd1, 4'd0,
                       lpsp_pkg::THR_W'($urandom_range(15)), 4'd2, 4'd15,
                       lpsp_pkg::THR_W'($urandom_range(15))};
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(ADDR_LIMIT, lpsp_pkg::APB_DW'(limits[p]));
            write_reg(ADDR_THRESHOLD, lpsp_pkg::APB_DW'(thresholds[p]));
            if (p == 0)
                hold_request = 1'b1;
            phase_start = sent_bytes;
            while (sent_bytes - phase_start < PHASE_BYTES)
                send_random_sequence();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
